### rtl/core/mac_whitelist_table_assert.svh
// Assertion macros used by the whitelist table datapath.
`ifndef MAC_WHITELIST_TABLE_ASSERT_SVH
`define MAC_WHITELIST_TABLE_ASSERT_SVH

`ifndef SYNTHESIS

// Checked property, disabled while reset is high.
`define MWT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("mac whitelist assertion failed");

// Checked property that also holds during reset.
`define MWT_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("mac whitelist assertion failed");

`else

`define MWT_ASSERT(lbl, clk, rst, prop)
`define MWT_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

### rtl/core/mwt_pkg.sv
// Shared types and constants of the MAC whitelist table.
package mwt_pkg;

   localparam int ADDR_W          = 48;
   localparam int OP_W            = 2;
   localparam int STATUS_W        = 2;
   localparam int COUNT_OUT_W     = 6;
   localparam int MAX_ENTRIES_DEF = 32;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_ADD    = 2'd2,
      OP_REMOVE = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_DONE      = 2'd0,
      STAT_DUPLICATE = 2'd1,
      STAT_NOT_FOUND = 2'd2,
      STAT_FULL      = 2'd3
   } status_type;

   // Controller to datapath.
   typedef struct packed {
      logic capture;   // latch transaction and register the compare result
      logic update;    // apply the operation and load the response register
   } mwt_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic rsp_stall; // response register holds a transaction not yet taken
   } mwt_stat_type;

endpackage

### rtl/core/mwt_ctrl.sv
// Controller state machine: accept, then update and respond.
module mwt_ctrl
   import mwt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  mwt_stat_type stat,
   output mwt_cmd_type  cmd
);

   typedef enum logic [1:0] {
      S_IDLE   = 2'b01,
      S_UPDATE = 2'b10
   } state_type;

   state_type state_ff, state_in;

   assign req_tready  = (state_ff == S_IDLE);
   assign cmd.capture = req_tvalid && req_tready;
   assign cmd.update  = (state_ff == S_UPDATE) && !stat.rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.capture) state_in = S_UPDATE;
         end
         S_UPDATE: begin
            if (cmd.update) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

### rtl/core/mwt_datapath.sv
// Address cells, parallel compare, remove shift, count and response register.
module mwt_datapath
   import mwt_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  mwt_cmd_type            cmd,
   output mwt_stat_type           stat,
   input  logic [OP_W-1:0]        req_op,
   input  logic [ADDR_W-1:0]      req_addr,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [COUNT_OUT_W-1:0] rsp_count
);

   `include "mac_whitelist_table_assert.svh"

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   logic [ADDR_W-1:0]      cell_ff [MAX_ENTRIES];
   logic [CNT_W-1:0]       count_ff, count_in;
   op_type                 op_ff;
   logic [ADDR_W-1:0]      addr_ff;
   logic [MAX_ENTRIES-1:0] match_ff, match_in;
   logic [MAX_ENTRIES-1:0] valid_vec;
   logic [MAX_ENTRIES-1:0] below_first;
   logic [MAX_ENTRIES-1:0] shift_sel;
   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             status_ff, status_in;
   logic [CNT_W+COUNT_OUT_W-1:0] count_wide;

   logic hit, full, store_en, shift_en;

   // Per-cell compare against the incoming address, limited to valid cells.
   for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cmp
      assign valid_vec[k] = (CNT_W'(k) < count_ff);
      assign match_in[k]  = valid_vec[k] && (cell_ff[k] == req_addr);
   end

   assign hit  = |match_ff;
   assign full = (count_ff == CNT_W'(MAX_ENTRIES));

   // Bits below the first match; cells at or above it take their upper neighbor.
   assign below_first = (match_ff ^ (match_ff - MAX_ENTRIES'(1))) >> 1;
   assign shift_sel   = ~below_first;

   always_comb begin
      count_in  = count_ff;
      status_in = STAT_DONE;
      store_en  = 1'b0;
      shift_en  = 1'b0;
      unique case (op_ff)
         OP_CLEAR: begin
            count_in = '0;
         end
         OP_APPEND: begin
            if (full) status_in = STAT_FULL;
            else      store_en  = 1'b1;
         end
         OP_ADD: begin
            if (hit)       status_in = STAT_DUPLICATE;
            else if (full) status_in = STAT_FULL;
            else           store_en  = 1'b1;
         end
         OP_REMOVE: begin
            if (hit) begin
               shift_en = 1'b1;
               count_in = count_ff - CNT_W'(1);
            end else begin
               status_in = STAT_NOT_FOUND;
            end
         end
         default: status_in = STAT_DONE;
      endcase
      if (store_en) count_in = count_ff + CNT_W'(1);
   end

   // Cell storage; contents after reset are don't-care until written.
   for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
      if (k < MAX_ENTRIES - 1) begin : g_shift
         always_ff @(posedge clock) begin
            if (cmd.update && shift_en && shift_sel[k]) begin
               cell_ff[k] <= cell_ff[k+1];
            end else if (cmd.update && store_en && (count_ff == CNT_W'(k))) begin
               cell_ff[k] <= addr_ff;
            end
         end
      end else begin : g_last
         always_ff @(posedge clock) begin
            if (cmd.update && store_en && (count_ff == CNT_W'(k))) begin
               cell_ff[k] <= addr_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= op_type'(req_op);
         addr_ff  <= req_addr;
         match_ff <= match_in;
      end
      if (cmd.update) status_ff <= status_in;
   end

   assign rsp_valid_in = cmd.update || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.update) count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign count_wide     = {{COUNT_OUT_W{1'b0}}, count_ff};
   assign stat.rsp_stall = rsp_valid_ff && !rsp_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_count      = count_wide[COUNT_OUT_W-1:0];

   `MWT_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(MAX_ENTRIES))
   `MWT_ASSERT(a_match_in_range, clock, reset, cmd.update |-> ((match_ff & ~valid_vec) == '0))
   `MWT_ASSERT(a_remove_dec, clock, reset,
      (cmd.update && op_ff == OP_REMOVE && hit) |=> (count_ff == $past(count_ff) - CNT_W'(1)))

endmodule

### rtl/core/mac_whitelist_table.sv
// Top level of the MAC address whitelist table.
//
// Input channel req_*: one transaction per table operation. req_tuser carries
// the operation (clear, append, add if absent, remove), req_tdata the 48-bit
// MAC address. Result channel rsp_*: exactly one transaction per request,
// rsp_tuser the status (done, duplicate, not found, full), rsp_tdata the
// number of valid entries after the operation.
// For each request, the accept cycle compares the address against every cell
// in parallel and registers the match vector; the update state then applies
// the operation (append at the end, remove with a one-cell shift of all later
// cells) and loads the response register. The response appears in the cycle
// after the update; a request is taken again in that same cycle, so the table
// takes no new request until the previous one has been updated.
// Reset empties the table (count to zero); cell contents are left undefined.
// If the receiver stalls, the response waits in its register; one further
// request may be accepted and is then held before its update until the
// waiting response is taken.
module mac_whitelist_table
   import mwt_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // [47:0] mac_addr
   input  logic [1:0]  req_tuser,   // [1:0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [5:0] entry_count, [7:6] zero
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   mwt_cmd_type             cmd;
   mwt_stat_type            stat;
   logic [COUNT_OUT_W-1:0]  rsp_count;

   mwt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   mwt_datapath #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_op     (req_tuser),
      .req_addr   (req_tdata),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_status (rsp_tuser),
      .rsp_count  (rsp_count)
   );

   assign rsp_tdata = {2'b00, rsp_count};

endmodule
